/* rtl/core/binomial_american_put_pricer_defines.svh */
// Assertion macros used by the pricer engine.
`ifndef BINOMIAL_AMERICAN_PUT_PRICER_DEFINES_SVH
`define BINOMIAL_AMERICAN_PUT_PRICER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BAP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BAP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bap_pkg.sv */
// Package with shared types, constants and arithmetic helpers of the pricer.
`timescale 1ns / 1ps
package bap_pkg;

    localparam int MAX_STEPS_DEF = 256;

    localparam logic [2:0] REG_UP_FACTOR  = 3'd0;
    localparam logic [2:0] REG_DOWN_SQ    = 3'd1;
    localparam logic [2:0] REG_UP_PROB    = 3'd2;
    localparam logic [2:0] REG_DISCOUNT   = 3'd3;
    localparam logic [2:0] REG_STEP_COUNT = 3'd4;

    localparam logic [31:0] ONE_Q30 = 32'h4000_0000;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
    localparam logic [8:0]  STEPS_RESET = 9'd1;

    typedef struct packed {
        logic [31:0] up_factor;
        logic [31:0] down_sq_factor;
        logic [31:0] up_prob;
        logic [31:0] discount;
        logic [8:0]  step_count;
    } cfg_t;

    // Rounds a Q2.30 product back to 32 bits; bit 32 of the result flags saturation.
    function automatic logic [32:0] round_asset(input logic [63:0] prod);
        logic [63:0] sum;
        logic        ovf;
        sum = prod + 64'h0000_0000_2000_0000;
        ovf = |sum[63:62];
        return {ovf, ovf ? 32'hFFFF_FFFF : sum[61:30]};
    endfunction

    function automatic logic [31:0] put_payoff(input logic [31:0] k, input logic [31:0] s);
        return (k > s) ? (k - s) : 32'd0;
    endfunction

endpackage

/* rtl/core/bap_ram.sv */
// Generic single-write, single-read RAM with a registered read.
`timescale 1ns / 1ps
module bap_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/bap_engine.sv */
// Lattice sequencer: builds the asset rows, the payoffs and folds rows back to the root.
`timescale 1ns / 1ps
`include "binomial_american_put_pricer_defines.svh"
module bap_engine #(
    parameter int MAX_STEPS = bap_pkg::MAX_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  bap_pkg::cfg_t cfg,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [31:0]  spot_price,
    input  logic [31:0]  strike_price,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [31:0]  put_price,
    output logic         saturated
);

    localparam int AW = $clog2(MAX_STEPS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_A_MUL = 4'd1;
    localparam logic [3:0] S_A_WR  = 4'd2;
    localparam logic [3:0] S_T_MUL = 4'd3;
    localparam logic [3:0] S_T_WR  = 4'd4;
    localparam logic [3:0] S_R_RD  = 4'd5;
    localparam logic [3:0] S_R_LD  = 4'd6;
    localparam logic [3:0] S_N_RD  = 4'd7;
    localparam logic [3:0] S_N_V   = 4'd8;
    localparam logic [3:0] S_N_M1  = 4'd9;
    localparam logic [3:0] S_N_MIX = 4'd10;
    localparam logic [3:0] S_N_MD  = 4'd11;
    localparam logic [3:0] S_N_WR  = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0]    state_reg, state_next;
    logic [AW-1:0] i_reg, i_next, j_reg, j_next, n_reg, n_next;
    logic          sat_reg, sat_next;
    logic [31:0]   a_reg, a_next, k_reg, k_next, p_reg, p_next, q_reg, q_next;
    logic [31:0]   disc_reg, disc_next, vu_reg, vu_next, vd_reg, vd_next;
    logic [31:0]   mix_reg, mix_next, res_reg, res_next;
    logic [63:0]   acc_reg, acc_next, prod_reg;
    logic [31:0]   mul_a, mul_b;
    logic          out_valid_reg, out_valid_next;
    logic [31:0]   put_reg, put_next;
    logic          outsat_reg, outsat_next;

    logic          rsa_we, or_we;
    logic [AW-1:0] rsa_waddr, or_waddr, or_raddr;
    logic [31:0]   rsa_wdata, or_wdata, rsa_rdata, or_rdata;

    logic [32:0]   rnd;
    logic [64:0]   mix_sum;
    logic [63:0]   cont_sum;
    logic [31:0]   cont, ex, a_use;
    logic [31:0]   sc_ext;
    logic [31:0]   n_calc;

    bap_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_rsa_ram (
        .clk(clk), .we(rsa_we), .waddr(rsa_waddr), .wdata(rsa_wdata),
        .raddr(i_reg), .rdata(rsa_rdata)
    );

    bap_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_opt_ram (
        .clk(clk), .we(or_we), .waddr(or_waddr), .wdata(or_wdata),
        .raddr(or_raddr), .rdata(or_rdata)
    );

    assign rnd      = bap_pkg::round_asset(prod_reg);
    assign mix_sum  = {1'b0, acc_reg} + {1'b0, prod_reg} + 65'h0_4000_0000;
    assign cont_sum = prod_reg + 64'h0000_0000_4000_0000;
    assign cont     = cont_sum[62:31];
    assign a_use    = (j_reg == '0) ? a_reg : rnd[31:0];
    assign ex       = bap_pkg::put_payoff(k_reg, a_reg);
    assign sc_ext   = {23'd0, cfg.step_count};
    assign n_calc   = (sc_ext == 32'd0) ? 32'd1 :
                      (sc_ext > 32'(MAX_STEPS)) ? 32'(MAX_STEPS) : sc_ext;
    assign or_raddr = (state_reg == S_R_RD) ? '0 : j_reg + AW'(1);

    always_comb
    begin
        unique case (state_reg)
            S_A_MUL: begin mul_a = a_reg;   mul_b = cfg.up_factor; end
            S_N_V:   begin mul_a = p_reg;   mul_b = vu_reg;        end
            S_N_M1:  begin mul_a = q_reg;   mul_b = vd_reg;        end
            S_N_MD:  begin mul_a = mix_reg; mul_b = disc_reg;      end
            default: begin mul_a = a_reg;   mul_b = cfg.down_sq_factor; end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        n_next         = n_reg;
        sat_next       = sat_reg;
        a_next         = a_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        disc_next      = disc_reg;
        vu_next        = vu_reg;
        vd_next        = vd_reg;
        mix_next       = mix_reg;
        res_next       = res_reg;
        acc_next       = acc_reg;
        put_next       = put_reg;
        outsat_next    = outsat_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rsa_we         = 1'b0;
        rsa_waddr      = i_reg;
        rsa_wdata      = rnd[31:0];
        or_we          = 1'b0;
        or_waddr       = j_reg;
        or_wdata       = ex;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rsa_we     = 1'b1;
                    rsa_waddr  = '0;
                    rsa_wdata  = spot_price;
                    a_next     = spot_price;
                    k_next     = strike_price;
                    p_next     = (cfg.up_prob > bap_pkg::ONE_Q31) ? bap_pkg::ONE_Q31 : cfg.up_prob;
                    q_next     = bap_pkg::ONE_Q31 - p_next;
                    disc_next  = (cfg.discount > bap_pkg::ONE_Q31) ? bap_pkg::ONE_Q31
                                                                   : cfg.discount;
                    n_next     = n_calc[AW-1:0];
                    i_next     = AW'(1);
                    sat_next   = 1'b0;
                    state_next = S_A_MUL;
                end
            end
            S_A_MUL:
            begin
                state_next = S_A_WR;
            end
            S_A_WR:
            begin
                rsa_we   = 1'b1;
                a_next   = rnd[31:0];
                sat_next = sat_reg | rnd[32];
                if (i_reg == n_reg)
                begin
                    j_next     = '0;
                    state_next = S_T_WR;
                end
                else
                begin
                    i_next     = i_reg + AW'(1);
                    state_next = S_A_MUL;
                end
            end
            S_T_MUL:
            begin
                state_next = S_T_WR;
            end
            S_T_WR:
            begin
                a_next   = a_use;
                sat_next = sat_reg | ((j_reg != '0) & rnd[32]);
                or_we    = 1'b1;
                or_wdata = bap_pkg::put_payoff(k_reg, a_use);
                if (j_reg == n_reg)
                begin
                    i_next     = n_reg - AW'(1);
                    state_next = S_R_RD;
                end
                else
                begin
                    j_next     = j_reg + AW'(1);
                    state_next = S_T_MUL;
                end
            end
            S_R_RD:
            begin
                j_next     = '0;
                state_next = S_R_LD;
            end
            S_R_LD:
            begin
                a_next     = rsa_rdata;
                vu_next    = or_rdata;
                state_next = S_N_RD;
            end
            S_N_RD:
            begin
                state_next = S_N_V;
            end
            S_N_V:
            begin
                vd_next = or_rdata;
                if (j_reg != '0)
                begin
                    a_next   = rnd[31:0];
                    sat_next = sat_reg | rnd[32];
                end
                state_next = S_N_M1;
            end
            S_N_M1:
            begin
                acc_next   = prod_reg;
                state_next = S_N_MIX;
            end
            S_N_MIX:
            begin
                mix_next   = mix_sum[62:31];
                state_next = S_N_MD;
            end
            S_N_MD:
            begin
                state_next = S_N_WR;
            end
            S_N_WR:
            begin
                if (i_reg == '0)
                begin
                    res_next   = cont;
                    state_next = S_DONE;
                end
                else
                begin
                    or_we    = 1'b1;
                    or_wdata = (ex > cont) ? ex : cont;
                    vu_next  = vd_reg;
                    if (j_reg == i_reg)
                    begin
                        i_next     = i_reg - AW'(1);
                        state_next = S_R_RD;
                    end
                    else
                    begin
                        j_next     = j_reg + AW'(1);
                        state_next = S_N_RD;
                    end
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    put_next       = res_reg;
                    outsat_next    = sat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg      <= i_next;
        j_reg      <= j_next;
        n_reg      <= n_next;
        sat_reg    <= sat_next;
        a_reg      <= a_next;
        k_reg      <= k_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        disc_reg   <= disc_next;
        vu_reg     <= vu_next;
        vd_reg     <= vd_next;
        mix_reg    <= mix_next;
        res_reg    <= res_next;
        acc_reg    <= acc_next;
        put_reg    <= put_next;
        outsat_reg <= outsat_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign put_price = put_reg;
    assign saturated = outsat_reg;

    `BAP_ASSERT_SAME(a_opt_ports_apart, or_we, or_waddr != or_raddr, "option row read and write collide")
    `BAP_ASSERT_SAME(a_node_in_row, state_reg == S_N_WR, j_reg <= i_reg, "node index beyond its row")
    `BAP_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "engine idle after a request")
    `BAP_ASSERT_SAME(a_row_in_range, state_reg == S_A_WR, (i_reg <= n_reg) && (i_reg != '0), "asset row out of range")

endmodule

/* rtl/core/binomial_american_put_pricer.sv */
// Top level of the binomial American put pricer: configuration registers and the engine.
// Usage:
// Software writes up_factor, down_sq_factor, up_prob, discount and step_count through
// cfg_we, cfg_index and cfg_data while the block is idle; indexes 5 to 7 are ignored.
// An input request carries spot_price and strike_price, both unsigned Q16.16, and is
// taken when in_valid and in_ready are high. Exactly one output request follows with
// put_price (Q16.16) and saturated, offered on out_valid until out_ready takes it.
// One request at a time is in the lattice: in_ready is high only between requests.
// The time a request takes is set by the one shared 32 by 32 multiplier, which serves
// four products per interior node, and by the single read port of the option row memory.
// A finished result waits in the output register; a new request is accepted while it
// waits, and a following result holds in the engine until the receiver takes the first.
// Reset returns the registers to u = 1, 1/u^2 = 1, p = 0.5, discount = 1 and N = 1,
// and clears the handshake state. The memories need no clearing pass, since every
// entry is written during a request before it is read.
`timescale 1ns / 1ps
module binomial_american_put_pricer #(
    parameter int MAX_STEPS = bap_pkg::MAX_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] spot_price,
    input  logic [31:0] strike_price,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] put_price,
    output logic        saturated
);

    bap_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.up_factor      <= bap_pkg::ONE_Q30;
            cfg_reg.down_sq_factor <= bap_pkg::ONE_Q30;
            cfg_reg.up_prob        <= bap_pkg::ONE_Q30;
            cfg_reg.discount       <= bap_pkg::ONE_Q31;
            cfg_reg.step_count     <= bap_pkg::STEPS_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bap_pkg::REG_UP_FACTOR:  cfg_reg.up_factor      <= cfg_data;
                bap_pkg::REG_DOWN_SQ:    cfg_reg.down_sq_factor <= cfg_data;
                bap_pkg::REG_UP_PROB:    cfg_reg.up_prob        <= cfg_data;
                bap_pkg::REG_DISCOUNT:   cfg_reg.discount       <= cfg_data;
                bap_pkg::REG_STEP_COUNT: cfg_reg.step_count     <= cfg_data[8:0];
                default:                 cfg_reg                <= cfg_reg;
            endcase
        end
    end

    bap_engine #(.MAX_STEPS(MAX_STEPS)) u_engine (
        .clk(clk),
        .rst_n(rst_n),
        .cfg(cfg_reg),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .spot_price(spot_price),
        .strike_price(strike_price),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .put_price(put_price),
        .saturated(saturated)
    );

endmodule

/* tb/sv/tb_binomial_american_put_pricer.sv */
// Self-checking testbench for the binomial American put pricer with a scoreboard class.
`timescale 1ns / 1ps
module tb_binomial_american_put_pricer;

    typedef struct {
        logic [31:0] price;
        logic        sat;
    } put_result_t;

    class put_scoreboard;
        logic [31:0] up_f;
        logic [31:0] down_sq;
        logic [31:0] prob;
        logic [31:0] disc;
        logic [8:0]  steps;
        logic [31:0] value_row[bap_pkg::MAX_STEPS_DEF + 1];
        logic [31:0] row_asset[bap_pkg::MAX_STEPS_DEF + 1];
        put_result_t pending_prices[$];
        int          errors;
        bit          sat_seen;

        function new();
            up_f = bap_pkg::ONE_Q30;
            down_sq = bap_pkg::ONE_Q30;
            prob = bap_pkg::ONE_Q30;
            disc = bap_pkg::ONE_Q31;
            steps = bap_pkg::STEPS_RESET;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] data);
            case (idx)
                bap_pkg::REG_UP_FACTOR:  up_f = data;
                bap_pkg::REG_DOWN_SQ:    down_sq = data;
                bap_pkg::REG_UP_PROB:    prob = data;
                bap_pkg::REG_DISCOUNT:   disc = data;
                bap_pkg::REG_STEP_COUNT: steps = data[8:0];
                default: ;
            endcase
        endfunction

        function logic [31:0] scale(logic [31:0] a, logic [31:0] f);
            logic [63:0] prod;
            prod = ({32'd0, a} * {32'd0, f} + 64'h2000_0000) >> 30;
            if (prod > 64'hFFFF_FFFF)
            begin
                sat_seen = 1;
                return 32'hFFFF_FFFF;
            end
            return prod[31:0];
        endfunction

        function logic [31:0] intrinsic(logic [31:0] k, logic [31:0] s);
            return (k > s) ? k - s : 32'd0;
        endfunction

        function logic [31:0] hold_value(logic [31:0] vu, logic [31:0] vd,
                                         logic [31:0] p, logic [31:0] d);
            logic [63:0] mix;
            logic [63:0] cont;
            mix = ({32'd0, p} * vu + ({32'd0, bap_pkg::ONE_Q31} - p) * vd
                   + 64'h4000_0000) >> 31;
            cont = (mix * d + 64'h4000_0000) >> 31;
            return cont[31:0];
        endfunction

        function void note_request(logic [31:0] s0, logic [31:0] k);
            logic [31:0] p;
            logic [31:0] d;
            logic [31:0] a;
            logic [31:0] ex;
            logic [31:0] c;
            int          n;
            put_result_t r;
            p = (prob > bap_pkg::ONE_Q31) ? bap_pkg::ONE_Q31 : prob;
            d = (disc > bap_pkg::ONE_Q31) ? bap_pkg::ONE_Q31 : disc;
            n = steps;
            if (n < 1) n = 1;
            if (n > bap_pkg::MAX_STEPS_DEF) n = bap_pkg::MAX_STEPS_DEF;
            sat_seen = 0;
            row_asset[0] = s0;
            for (int i = 1; i <= n; i++) row_asset[i] = scale(row_asset[i - 1], up_f);
            a = row_asset[n];
            for (int j = 0; j <= n; j++)
            begin
                if (j > 0) a = scale(a, down_sq);
                value_row[j] = intrinsic(k, a);
            end
            for (int i = n - 1; i >= 1; i--)
            begin
                a = row_asset[i];
                for (int j = 0; j <= i; j++)
                begin
                    if (j > 0) a = scale(a, down_sq);
                    ex = intrinsic(k, a);
                    c = hold_value(value_row[j], value_row[j + 1], p, d);
                    value_row[j] = (ex > c) ? ex : c;
                end
            end
            r.price = hold_value(value_row[0], value_row[1], p, d);
            r.sat = sat_seen;
            pending_prices.push_back(r);
        endfunction

        function void check_result(logic [31:0] price, logic sat);
            put_result_t r;
            if (pending_prices.size() == 0)
            begin
                $error("unexpected result put_price=%h saturated=%b", price, sat);
                errors++;
                return;
            end
            r = pending_prices.pop_front();
            if (price !== r.price)
            begin
                $error("put_price expected %h actual %h", r.price, price);
                errors++;
            end
            if (sat !== r.sat)
            begin
                $error("saturated expected %b actual %b", r.sat, sat);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_ready;
    logic [31:0] spot_price = '0;
    logic [31:0] strike_price = '0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [31:0] put_price;
    logic        saturated;

    put_scoreboard sb = new();
    longint cycles = 0;
    bit     send_done = 0;

    binomial_american_put_pricer uut (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd20_000_000)
        begin
            $display("FAIL binomial_american_put_pricer");
            $finish;
        end
    end

    function int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic write_cfg(logic [2:0] idx, logic [31:0] data);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_we <= 0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    task automatic send_request(logic [31:0] s0, logic [31:0] k);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1;
        spot_price <= s0;
        strike_price <= k;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_request(s0, k);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_prices.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_lattice(logic [31:0] u, logic [31:0] dsq, logic [31:0] p,
                               logic [31:0] d, logic [8:0] n);
        write_cfg(bap_pkg::REG_UP_FACTOR, u);
        write_cfg(bap_pkg::REG_DOWN_SQ, dsq);
        write_cfg(bap_pkg::REG_UP_PROB, p);
        write_cfg(bap_pkg::REG_DISCOUNT, d);
        write_cfg(bap_pkg::REG_STEP_COUNT, {23'd0, n});
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_result(put_price, saturated);
    end

    always @(posedge clk)
    begin
        if (!rst_n) out_ready <= 0;
        else if ($urandom_range(0, 3) == 0) out_ready <= ($urandom_range(0, 9) == 0);
        else out_ready <= 1;
    end

    initial
    begin
        logic [31:0] u;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_request(32'h0001_0000, 32'h0002_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        drain();
        set_lattice(32'h4400_0000, 32'h3880_0000, 32'h4000_0000, 32'h7FF0_0000, 9'd4);
        send_request(32'h0064_0000, 32'h0064_0000);
        send_request(32'h0050_0000, 32'h0064_0000);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();
        set_lattice(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 9'd0);
        send_request(32'h8000_0000, 32'h9000_0000);
        send_request(32'h0001_0000, 32'hFFFF_FFFF);
        drain();
        set_lattice(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 9'd3);
        send_request(32'h1234_5678, 32'h2000_0000);
        drain();
        write_cfg(3'd5, 32'h0);
        write_cfg(3'd7, 32'hFFFF_FFFF);
        set_lattice(32'h4100_0000, 32'h3E00_0000, 32'h8000_0001, 32'h8000_0000, 9'd511);
        send_request(32'h0064_0000, 32'h0070_0000);
        drain();
        set_lattice(32'h4100_0000, 32'h3E00_0000, 32'h4200_0000, 32'h7FFF_0000, 9'd256);
        send_request(32'h0064_0000, 32'h0064_0000);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            u = 32'h4000_0000 + $urandom_range(0, 32'h0400_0000);
            set_lattice(u, 32'h4000_0000 - $urandom_range(0, 32'h0700_0000),
                        $urandom_range(0, 32'h8000_0000), $urandom_range(32'h7000_0000,
                        32'h8000_0000), 9'($urandom_range(1, 12)));
            if (ph == 7) write_cfg(bap_pkg::REG_UP_FACTOR, $urandom());
            for (int i = 0; i < 11; i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_request($urandom(), $urandom());
                else
                    send_request($urandom_range(32'h0010_0000, 32'h0100_0000),
                                 $urandom_range(32'h0010_0000, 32'h0100_0000));
                if (i == 5) drain();
            end
            drain();
        end

        drain();
        repeat (100) @(posedge clk);
        if (sb.errors == 0 && sb.pending_prices.size() == 0)
            $display("PASS binomial_american_put_pricer");
        else
            $display("FAIL binomial_american_put_pricer");
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/bap_pkg.sv
rtl/core/bap_ram.sv
rtl/core/bap_engine.sv
rtl/core/binomial_american_put_pricer.sv
tb/sv/tb_binomial_american_put_pricer.sv
